@@ rtl/core/sfc_pkg.sv @@
// shared types and constants for the sphere/frustum classifier
// no dependencies; imported by every module in rtl/core
`default_nettype none

package sfc_pkg;

	// plane register file
	localparam int REG_COUNT       = 6;
	localparam int REG_IDX_W       = 3;
	localparam int APB_ADDR_W      = 6;
	localparam int APB_DATA_W      = 64;
	localparam int PLANE_COUNT_DEF = 6;

	// arithmetic widths: Q1.14 normals times 16-bit coordinates
	localparam int COORD_W = 16;
	localparam int RAD_W   = 15;
	localparam int PROD_W  = 32;
	localparam int Q_SHIFT = 14;
	// three products plus the shifted offset stay below 2^33 in magnitude
	localparam int DIST_W  = 34;

	// one plane as packed in its register, offset in the top half-word
	typedef struct packed {
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nx;
	} plane_t;

	// result codes
	typedef enum logic [1:0] {
		CLS_OUTSIDE   = 2'd0,
		CLS_INTERSECT = 2'd1,
		CLS_INSIDE    = 2'd2
	} cls_t;

	// stage load enables handed from the top level to the datapath
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/sfc_plane_regs.sv @@
// apb register file holding the six frustum planes
// depends on sfc_pkg
`default_nettype none

module sfc_plane_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sfc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sfc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output sfc_pkg::plane_t                 planes [sfc_pkg::REG_COUNT]
);
	import sfc_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 idx_ok;
	logic                 wr_en;
	plane_t               planes_q [REG_COUNT];

	// one 64-bit register every eight bytes
	assign reg_idx = paddr[APB_ADDR_W-1:3];
	assign idx_ok  = (32'(reg_idx) < REG_COUNT);
	assign wr_en   = psel && penable && pwrite && idx_ok;
	assign pready  = 1'b1;

	// plane storage, writes beyond the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en) begin
			planes_q[reg_idx] <= plane_t'(pwdata);
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = APB_DATA_W'(planes_q[reg_idx]);
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

@@ rtl/core/sfc_plane_dist.sv @@
// signed distance of the sphere centre to one plane, two register stages
// depends on sfc_pkg; control enables come from the top level
`default_nettype none

module sfc_plane_dist (
	input  logic                               clk,
	input  sfc_pkg::pipe_ctl_t                 ctl,
	input  sfc_pkg::plane_t                    plane,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_z,
	output logic signed [sfc_pkg::DIST_W-1:0]  dist_s2
);
	import sfc_pkg::*;

	logic signed [PROD_W-1:0]  prod_x_s1;
	logic signed [PROD_W-1:0]  prod_y_s1;
	logic signed [PROD_W-1:0]  prod_z_s1;
	logic signed [COORD_W-1:0] ofs_s1;

	// stage 1: the three 16x16 products
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_x_s1 <= PROD_W'(plane.nx * center_x);
			prod_y_s1 <= PROD_W'(plane.ny * center_y);
			prod_z_s1 <= PROD_W'(plane.nz * center_z);
			ofs_s1    <= plane.d;
		end
	end

	// stage 2: sum with the offset scaled to units of 2^-14
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			dist_s2 <= DIST_W'(prod_x_s1) + DIST_W'(prod_y_s1) + DIST_W'(prod_z_s1)
				+ (DIST_W'(ofs_s1) <<< Q_SHIFT);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sfc_classify.sv @@
// compares every plane distance with the radius and forms the result code
// depends on sfc_pkg; distances come from sfc_plane_dist lanes
`default_nettype none

module sfc_classify #(
	parameter int LANES = sfc_pkg::PLANE_COUNT_DEF
) (
	input  logic                              clk,
	input  sfc_pkg::pipe_ctl_t                ctl,
	input  logic signed [sfc_pkg::DIST_W-1:0] dist_s2 [LANES],
	input  logic [sfc_pkg::RAD_W-1:0]         radius_s2,
	output sfc_pkg::cls_t                     class_s3
);
	import sfc_pkg::*;

	logic signed [DIST_W-1:0] rad_pos;
	logic signed [DIST_W-1:0] rad_neg;
	logic                     any_out;
	logic                     any_cross;
	cls_t                     class_next;

	// radius in the same units as the distances
	assign rad_pos = signed'(DIST_W'(radius_s2)) <<< Q_SHIFT;
	assign rad_neg = -rad_pos;

	// per-plane tests, or-reduced over the lanes
	always_comb begin
		any_out   = 1'b0;
		any_cross = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (dist_s2[i] < rad_neg) begin
				any_out = 1'b1;
			end else if (dist_s2[i] < rad_pos) begin
				any_cross = 1'b1;
			end
		end
		if (any_out) begin
			class_next = CLS_OUTSIDE;
		end else if (any_cross) begin
			class_next = CLS_INTERSECT;
		end else begin
			class_next = CLS_INSIDE;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			class_s3 <= class_next;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sphere_frustum_classify_core.sv @@
// top level of the sphere/frustum classifier: pipeline control and lanes
// depends on sfc_pkg, sfc_plane_regs, sfc_plane_dist, sfc_classify
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+------------------------------
//  sphere    | in        | sphere_valid/sphere_stall| center_x/y/z, sphere_radius
//  class     | out       | class_valid/class_stall  | classification
//  apb       | in/out    | psel/penable/pready      | paddr, pwdata, prdata
//
// one request per cycle while sphere_stall is low; each passes the product stage, sum stage and compare stage
// reset clears the stage valid bits and the plane registers to zero
// a stalled result holds in the output register; earlier stages keep filling
// bubbles, and sphere_stall rises only when all three stages are occupied
`default_nettype none

module sphere_frustum_classify_core #(
	parameter int PLANE_COUNT = sfc_pkg::PLANE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sphere_valid,
	output logic                               sphere_stall,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_z,
	input  logic [sfc_pkg::RAD_W-1:0]          sphere_radius,
	output logic                               class_valid,
	input  logic                               class_stall,
	output logic [1:0]                         classification,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sfc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [sfc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [sfc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import sfc_pkg::*;

	// planes beyond the register file are not there
	localparam int LANES = (PLANE_COUNT > REG_COUNT) ? REG_COUNT : PLANE_COUNT;

	plane_t                   planes [REG_COUNT];
	pipe_ctl_t                ctl;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic [RAD_W-1:0]         radius_s1;
	logic [RAD_W-1:0]         radius_s2;
	logic signed [DIST_W-1:0] dist_s2 [LANES];
	cls_t                     class_s3;

	// plane registers
	sfc_plane_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	// stage enables: a stage loads when it is empty or its successor moves
	assign ctl.en_s3    = !v_s3 || !class_stall;
	assign ctl.en_s2    = !v_s2 || ctl.en_s3;
	assign ctl.en_s1    = !v_s1 || ctl.en_s2;
	assign sphere_stall = !ctl.en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				v_s1 <= sphere_valid;
			end
			if (ctl.en_s2) begin
				v_s2 <= v_s1;
			end
			if (ctl.en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// radius travels alongside the distances
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			radius_s1 <= sphere_radius;
		end
		if (ctl.en_s2) begin
			radius_s2 <= radius_s1;
		end
	end

	// one distance lane per tested plane
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		sfc_plane_dist u_dist (
			.clk      (clk),
			.ctl      (ctl),
			.plane    (planes[g]),
			.center_x (center_x),
			.center_y (center_y),
			.center_z (center_z),
			.dist_s2  (dist_s2[g])
		);
	end

	// compare and reduce
	sfc_classify #(
		.LANES (LANES)
	) u_cls (
		.clk       (clk),
		.ctl       (ctl),
		.dist_s2   (dist_s2),
		.radius_s2 (radius_s2),
		.class_s3  (class_s3)
	);

	assign class_valid    = v_s3;
	assign classification = class_s3;

	// input is held off only with every stage full and the output stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_stall |-> (v_s1 && v_s2 && v_s3 && class_stall))
		else $error("input stalled with room in the pipeline");

	// an accepted request lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(sphere_valid && !sphere_stall) |=> v_s1)
		else $error("accepted request lost before stage 1");

	// an empty sum stage never produces a result
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s2 && ctl.en_s3) |=> !class_valid)
		else $error("result produced from an empty stage");

endmodule

`default_nettype wire

@@ tb/sphere_frustum_classify_core_tb.sv @@
// self-checking testbench for sphere_frustum_classify_core: APB plane setup, random sphere stream
// depends on sfc_pkg and the core; predicts each classification and checks it in order
`default_nettype none

module sphere_frustum_classify_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfc_pkg::*;

	localparam int PLANES    = PLANE_COUNT_DEF;
	localparam longint Q_ONE = longint'(1) << Q_SHIFT;

	// one sphere request as it sits on the input ports
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [RAD_W-1:0]          rad;
	} sphere_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      sphere_valid  = 1'b0;
	logic                      sphere_stall;
	logic signed [COORD_W-1:0] center_x      = '0;
	logic signed [COORD_W-1:0] center_y      = '0;
	logic signed [COORD_W-1:0] center_z      = '0;
	logic [RAD_W-1:0]          sphere_radius = '0;
	logic                      class_valid;
	logic                      class_stall   = 1'b0;
	logic [1:0]                classification;
	logic                      psel          = 1'b0;
	logic                      penable       = 1'b0;
	logic                      pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0]     paddr         = '0;
	logic [APB_DATA_W-1:0]     pwdata        = '0;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;

	// testbench copy of the plane registers
	logic [63:0] plane_copy [REG_COUNT];

	sphere_req_t sphere_req_q [$];
	cls_t        class_expect_q [$];

	// idle mixes: receiver-heavy, sender-heavy, none
	int idle_mode = 0;
	int send_idle_pct [3] = '{33, 54, 0};
	int recv_stall_pct [3] = '{54, 33, 0};

	int mismatch_count = 0;
	int spheres_sent   = 0;
	int plane_settings = 0;
	int cls_seen [3]   = '{0, 0, 0};

	sphere_frustum_classify_core #(
		.PLANE_COUNT(PLANES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sphere_valid(sphere_valid),
		.sphere_stall(sphere_stall),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.sphere_radius(sphere_radius),
		.class_valid(class_valid),
		.class_stall(class_stall),
		.classification(classification),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// expected class: any plane beyond the far side of the sphere wins, then any straddle
	function automatic cls_t classify_sphere(logic signed [COORD_W-1:0] cx,
		logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] cz, logic [RAD_W-1:0] rad);
		plane_t pl;
		longint plane_sep;
		longint reach;
		bit cut;
		bit straddle;
		reach = longint'($signed({1'b0, rad})) * Q_ONE;
		cut = 1'b0;
		straddle = 1'b0;
		for (int i = 0; i < PLANES && i < REG_COUNT; i++) begin
			pl = plane_t'(plane_copy[i]);
			plane_sep = longint'($signed(pl.nx)) * longint'(cx)
				+ longint'($signed(pl.ny)) * longint'(cy)
				+ longint'($signed(pl.nz)) * longint'(cz)
				+ longint'($signed(pl.d)) * Q_ONE;
			if (plane_sep < -reach)
				cut = 1'b1;
			else if (plane_sep < reach)
				straddle = 1'b1;
		end
		if (cut)
			return CLS_OUTSIDE;
		else if (straddle)
			return CLS_INTERSECT;
		return CLS_INSIDE;
	endfunction

	function automatic void push_sphere(int cx, int cy, int cz, int rad);
		sphere_req_t rq;
		rq.cx = COORD_W'(cx);
		rq.cy = COORD_W'(cy);
		rq.cz = COORD_W'(cz);
		rq.rad = RAD_W'(rad);
		sphere_req_q.push_back(rq);
	endfunction

	// apb write: setup then access; indexes past the register file must be ignored
	task automatic write_plane_reg(int idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < REG_COUNT)
			plane_copy[idx] = value;
	endtask

	// wait until every queued request is accepted and every class has come back
	task automatic drain_spheres();
		do
			@(negedge clk);
		while (sphere_req_q.size() != 0 || sphere_valid || class_expect_q.size() != 0);
	endtask

	// request driver: predict on acceptance, then present the next request or idle
	always @(posedge clk) begin
		sphere_req_t nxt;
		if (arst_n) begin
			if (sphere_valid && !sphere_stall) begin
				class_expect_q.push_back(classify_sphere(center_x, center_y, center_z,
					sphere_radius));
				spheres_sent++;
			end
			if (!sphere_valid || !sphere_stall) begin
				if (sphere_req_q.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct[idle_mode]) begin
					nxt = sphere_req_q.pop_front();
					center_x <= nxt.cx;
					center_y <= nxt.cy;
					center_z <= nxt.cz;
					sphere_radius <= nxt.rad;
					sphere_valid <= 1'b1;
				end else begin
					sphere_valid <= 1'b0;
				end
			end
		end
	end

	// class monitor and receiver stall
	always @(posedge clk) begin
		cls_t want;
		if (arst_n) begin
			if (class_valid && !class_stall) begin
				if (class_expect_q.size() == 0) begin
					$display("%0t: unexpected class, expected none, got %0d", $time,
						classification);
					mismatch_count++;
				end else begin
					want = class_expect_q.pop_front();
					if (classification !== want) begin
						$display("%0t: classification wrong, expected %0d (%s), got %0d",
							$time, want, want.name(), classification);
						mismatch_count++;
					end else begin
						cls_seen[want]++;
					end
				end
			end
			class_stall <= ($urandom_range(0, 99) < recv_stall_pct[idle_mode]);
		end
	end

	// run limit
	initial begin
		#(5ms);
		$display("%0t: run limit reached, %0d classes outstanding", $time,
			class_expect_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus sequence
	initial begin
		plane_t pl;
		logic [63:0] val;
		for (int i = 0; i < REG_COUNT; i++)
			plane_copy[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// planes at reset are all zero: point test inside, any radius straddles
		plane_settings++;
		push_sphere(0, 0, 0, 0);
		push_sphere(0, 0, 0, 1);
		push_sphere(-32768, 32767, -32768, 32767);
		drain_spheres();

		// axis-aligned box of half-size 100 around the origin
		write_plane_reg(0, {16'sd100, 16'sd0, -16'sd16384, 16'sd0});
		write_plane_reg(1, {16'sd100, 16'sd0, 16'sd16384, 16'sd0});
		write_plane_reg(2, {16'sd100, 16'sd0, 16'sd0, 16'sd16384});
		write_plane_reg(3, {16'sd100, 16'sd0, 16'sd0, -16'sd16384});
		write_plane_reg(4, {16'sd100, 16'sd16384, 16'sd0, 16'sd0});
		write_plane_reg(5, {16'sd100, -16'sd16384, 16'sd0, 16'sd0});
		plane_settings++;
		push_sphere(0, 0, 0, 0);
		push_sphere(0, 0, 0, 50);
		push_sphere(0, 0, 0, 150);
		push_sphere(300, 0, 0, 10);
		// point exactly on a plane, and just past it
		push_sphere(100, 0, 0, 0);
		push_sphere(101, 0, 0, 0);
		// centre on the plane with a radius
		push_sphere(100, 0, 0, 5);
		// distance equal to minus the radius, then one unit further
		push_sphere(105, 0, 0, 5);
		push_sphere(106, 0, 0, 5);
		// distance equal to the radius, then a z plane one unit past minus the radius
		push_sphere(95, 0, 0, 5);
		push_sphere(0, 0, -106, 5);
		drain_spheres();

		// writes past the last register must leave the planes alone
		write_plane_reg(6, {$urandom(), $urandom()});
		write_plane_reg(7, {$urandom(), $urandom()});
		push_sphere(0, 0, 0, 50);
		drain_spheres();

		// field extremes in every plane, including one all-zero plane
		write_plane_reg(0, 64'h8000_8000_8000_8000);
		write_plane_reg(1, 64'h7FFF_7FFF_7FFF_7FFF);
		write_plane_reg(2, 64'hFFFF_FFFF_FFFF_FFFF);
		write_plane_reg(3, 64'h0000_0000_0000_0000);
		write_plane_reg(4, 64'h8000_7FFF_8000_7FFF);
		write_plane_reg(5, 64'h7FFF_8000_7FFF_8000);
		plane_settings++;
		push_sphere(-32768, -32768, -32768, 32767);
		push_sphere(32767, 32767, 32767, 0);
		push_sphere(32767, -32768, 32767, 32767);
		push_sphere(-32768, 32767, -32768, 0);
		push_sphere(0, 0, 0, 32767);
		drain_spheres();

		// random phases: frustum-like planes with the origin inside, last one raw noise
		for (int s = 0; s < 6; s++) begin
			idle_mode = s / 2;
			for (int i = 0; i < REG_COUNT; i++) begin
				if (s == 5) begin
					val = {$urandom(), $urandom()};
				end else begin
					pl.nx = COORD_W'($urandom_range(0, 32768) - 16384);
					pl.ny = COORD_W'($urandom_range(0, 32768) - 16384);
					pl.nz = COORD_W'($urandom_range(0, 32768) - 16384);
					pl.d = COORD_W'($urandom_range(0, 4000));
					val = pl;
				end
				write_plane_reg(i, val);
			end
			plane_settings++;
			for (int k = 0; k < 242; k++) begin
				if ($urandom_range(0, 9) < 7)
					push_sphere($urandom_range(0, 6000) - 3000,
						$urandom_range(0, 6000) - 3000,
						$urandom_range(0, 6000) - 3000,
						($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1500));
				else
					push_sphere($urandom(), $urandom(), $urandom(), $urandom());
			end
			drain_spheres();
		end

		// quiet wait to catch any stray class
		repeat (20) @(posedge clk);
		if (class_expect_q.size() != 0) begin
			$display("%0t: %0d classes never arrived", $time, class_expect_q.size());
			mismatch_count++;
		end
		$display("checked %0d spheres under %0d plane settings", spheres_sent, plane_settings);
		$display("outside %0d, intersecting %0d, inside %0d", cls_seen[CLS_OUTSIDE],
			cls_seen[CLS_INTERSECT], cls_seen[CLS_INSIDE]);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
